/* src/ring_poly_mac_trinomial_macros.svh */
// assertion macros for the ring polynomial multiply-accumulate block
// no dependencies; included by the modules that carry assertions
`ifndef RING_POLY_MAC_TRINOMIAL_MACROS_SVH
`define RING_POLY_MAC_TRINOMIAL_MACROS_SVH

// same-cycle implication, checked out of reset
`define RPMT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RPMT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rpmt_pkg.sv */
// types, codes and microcode rom of the ring polynomial multiply-accumulate block
// no dependencies; imported by ring_poly_mac_trinomial and its bench
`timescale 1ns / 1ps

package rpmt_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_MAC  = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  // sign pattern of one product term of an output coefficient
  typedef enum logic [1:0] {
    TERM_PLAIN   = 2'd0,  // +a_i * b_j
    TERM_DIFF    = 2'd1,  // +a_i * (b_0 - b_{n-1})
    TERM_NEG_SUM = 2'd2,  // -a_i * (b_j + b_{j-1})
    TERM_NEG     = 2'd3   // -a_i * b_j, coefficient zero only
  } term_e;

  // datapath action of one microcode step
  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_CLR       = 4'd1,
    ACT_TAKE      = 4'd2,
    ACT_LOAD      = 4'd3,
    ACT_RD_ISSUE  = 4'd4,
    ACT_OUT_LOAD  = 4'd5,
    ACT_MAC_INIT  = 4'd6,
    ACT_MAC_ISSUE = 4'd7,
    ACT_ACC_FETCH = 4'd8,
    ACT_ACC_WB    = 4'd9
  } act_e;

  // sequencing: jump to target when the condition holds, else step on
  typedef enum logic [2:0] {
    COND_NEXT       = 3'd0,
    COND_ALWAYS     = 3'd1,
    COND_NOT_LAST_I = 3'd2,
    COND_NOT_LAST_K = 3'd3,
    COND_OUT_BUSY   = 3'd4,
    COND_DISPATCH   = 3'd5
  } cond_e;

  localparam int UC_AW = 4;

  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic [UC_AW-1:0] target;
  } uc_word_t;

  // step addresses
  localparam logic [UC_AW-1:0] S_CLR       = 4'd0;
  localparam logic [UC_AW-1:0] S_IDLE      = 4'd1;
  localparam logic [UC_AW-1:0] S_LOAD      = 4'd2;
  localparam logic [UC_AW-1:0] S_RD0       = 4'd3;
  localparam logic [UC_AW-1:0] S_RD1       = 4'd4;
  localparam logic [UC_AW-1:0] S_RD_RET    = 4'd5;
  localparam logic [UC_AW-1:0] S_MAC_INIT  = 4'd6;
  localparam logic [UC_AW-1:0] S_MAC_ISSUE = 4'd7;
  localparam logic [UC_AW-1:0] S_DRAIN0    = 4'd8;
  localparam logic [UC_AW-1:0] S_DRAIN1    = 4'd9;
  localparam logic [UC_AW-1:0] S_DRAIN2    = 4'd10;
  localparam logic [UC_AW-1:0] S_MAC_WB    = 4'd11;
  localparam logic [UC_AW-1:0] S_MAC_RET   = 4'd12;

  // the program
  function automatic uc_word_t uc_rom(input logic [UC_AW-1:0] pc);
    uc_word_t w;
    w = '{act: ACT_NONE, cond: COND_ALWAYS, target: S_IDLE};
    case (pc)
      S_CLR:       w = '{act: ACT_CLR,       cond: COND_NOT_LAST_K, target: S_CLR};
      S_IDLE:      w = '{act: ACT_TAKE,      cond: COND_DISPATCH,   target: S_IDLE};
      S_LOAD:      w = '{act: ACT_LOAD,      cond: COND_ALWAYS,     target: S_IDLE};
      S_RD0:       w = '{act: ACT_RD_ISSUE,  cond: COND_NEXT,       target: S_IDLE};
      S_RD1:       w = '{act: ACT_OUT_LOAD,  cond: COND_OUT_BUSY,   target: S_RD1};
      S_RD_RET:    w = '{act: ACT_NONE,      cond: COND_ALWAYS,     target: S_IDLE};
      S_MAC_INIT:  w = '{act: ACT_MAC_INIT,  cond: COND_NEXT,       target: S_IDLE};
      S_MAC_ISSUE: w = '{act: ACT_MAC_ISSUE, cond: COND_NOT_LAST_I, target: S_MAC_ISSUE};
      S_DRAIN0:    w = '{act: ACT_ACC_FETCH, cond: COND_NEXT,       target: S_IDLE};
      S_DRAIN1:    w = '{act: ACT_NONE,      cond: COND_NEXT,       target: S_IDLE};
      S_DRAIN2:    w = '{act: ACT_NONE,      cond: COND_NEXT,       target: S_IDLE};
      S_MAC_WB:    w = '{act: ACT_ACC_WB,    cond: COND_NOT_LAST_K, target: S_MAC_ISSUE};
      S_MAC_RET:   w = '{act: ACT_NONE,      cond: COND_ALWAYS,     target: S_IDLE};
      default:     w = '{act: ACT_NONE,      cond: COND_ALWAYS,     target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* src/ring_poly_mac_trinomial.sv */
// ring polynomial multiply-accumulate in Z[x]/(x^n + x + 1), microcoded top level
// depends on rpmt_pkg and ring_poly_mac_trinomial_macros.svh
`timescale 1ns / 1ps

// channel   dir  tdata (low bit up)                                      tuser  other
// s_axis    in   coef_index[5:0] coef_a[37:6] coef_b[69:38]              kind   tvalid/tready
//                clear_first[70], zero pad to 72
// m_axis    out  read_value[63:0]                                        -      tvalid/tready
//
// load item: take, then operand write; read item: accumulator read, then output register
//   load, with a wait while the output register is busy; multiply item: per output
//   coefficient one issue for each a index, one 32x33 product each through the single
//   shared multiplier, then pipeline drain and write-back
// after reset a clearing pass zeroes the accumulator memory;
//   no item is taken during it
// a finished read result waits in the output register; the next item is taken meanwhile

module ring_poly_mac_trinomial
  import rpmt_pkg::*;
#(
  parameter int DEGREE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // coef_index[5:0], coef_a[37:6], coef_b[69:38], clear_first[70], zeros[71]
  input  logic [71:0] s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_value[63:0]
  output logic [63:0] m_axis_tdata_o
);

`include "ring_poly_mac_trinomial_macros.svh"

  localparam int IW = (DEGREE > 1) ? $clog2(DEGREE) : 1;
  localparam logic [IW-1:0] LAST = IW'(DEGREE - 1);

  // operand and accumulator memories, no reset
  logic [31:0] mem_a_q   [DEGREE];
  logic [31:0] mem_b_q   [DEGREE];
  logic [63:0] mem_acc_q [DEGREE];

  // sequencer
  logic [UC_AW-1:0] pc_q, pc_d;
  uc_word_t         uc;

  // loop counters: k = output coefficient, i = a index, j = b index (k-i mod n)
  logic [IW-1:0] k_q, k_d, i_q, i_d, j_q, j_d;
  logic [IW-1:0] j_next;

  // latched input item
  logic [5:0]  idx_q;
  logic [31:0] coef_a_q, coef_b_q;
  logic        clear_q;
  logic        idx_ok;

  // handshakes
  logic s_in_fire;
  logic out_free;
  logic out_load;
  logic m_valid_q, m_valid_d;
  logic [63:0] m_data_q;

  // memory ports
  logic          op_we;
  logic          op_re;
  logic          acc_we, acc_re;
  logic [IW-1:0] acc_waddr, acc_raddr;
  logic [63:0]   acc_wdata;
  logic [63:0]   acc_rdata_q;

  // product pipeline
  logic               v1_q, v1_d;
  term_e              mode1_q, mode1_d;
  logic signed [31:0] a_rd_q, b0_rd_q, b1_rd_q;
  logic               v2_q, neg2_q;
  logic signed [31:0] a2_q;
  logic signed [32:0] d2_q, d1;
  logic signed [32:0] b0x, b1x;
  logic signed [64:0] prod;
  logic               v3_q, neg3_q;
  logic [63:0]        p_q;
  logic [63:0]        sum_q, sum_d;
  logic               sum_clr;

  assign uc        = uc_rom(pc_q);
  assign s_axis_tready_o = (uc.act == ACT_TAKE);
  assign s_in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign idx_ok    = (32'(idx_q) < DEGREE);
  assign j_next    = (j_q == '0) ? LAST : j_q - 1'b1;

  // next step
  always_comb begin
    pc_d = pc_q + 1'b1;
    case (uc.cond)
      COND_NEXT:       pc_d = pc_q + 1'b1;
      COND_ALWAYS:     pc_d = uc.target;
      COND_NOT_LAST_I: pc_d = (i_q != LAST) ? uc.target : pc_q + 1'b1;
      COND_NOT_LAST_K: pc_d = (k_q != LAST) ? uc.target : pc_q + 1'b1;
      COND_OUT_BUSY:   pc_d = !out_free ? uc.target : pc_q + 1'b1;
      COND_DISPATCH: begin
        pc_d = uc.target;
        if (s_in_fire) begin
          case (s_axis_tuser_i)
            KIND_LOAD: pc_d = S_LOAD;
            KIND_MAC:  pc_d = S_MAC_INIT;
            KIND_READ: pc_d = S_RD0;
            default:   pc_d = uc.target;  // unused kind, dropped
          endcase
        end
      end
      default:         pc_d = uc.target;
    endcase
  end

  // datapath control from the current control word
  always_comb begin
    k_d       = k_q;
    i_d       = i_q;
    j_d       = j_q;
    op_we     = 1'b0;
    op_re     = 1'b0;
    acc_we    = 1'b0;
    acc_re    = 1'b0;
    acc_waddr = k_q;
    acc_raddr = k_q;
    acc_wdata = '0;
    out_load  = 1'b0;
    v1_d      = 1'b0;
    mode1_d   = TERM_PLAIN;
    sum_clr   = 1'b0;
    case (uc.act)
      ACT_CLR: begin
        acc_we = 1'b1;
        k_d    = k_q + 1'b1;
      end
      ACT_LOAD: begin
        op_we = idx_ok;
      end
      ACT_RD_ISSUE: begin
        acc_re    = 1'b1;
        acc_raddr = IW'(idx_q);
      end
      ACT_OUT_LOAD: begin
        out_load = out_free;
      end
      ACT_MAC_INIT: begin
        k_d     = '0;
        i_d     = '0;
        j_d     = '0;
        sum_clr = 1'b1;
      end
      ACT_MAC_ISSUE: begin
        op_re = 1'b1;
        v1_d  = 1'b1;
        if (i_q < k_q) begin
          mode1_d = TERM_PLAIN;
        end else if (k_q == '0) begin
          // coefficient zero gets no fold from x^(n-1): plain a_0*b_0, then single
          // negated terms from x^n
          mode1_d = (i_q == '0) ? TERM_PLAIN : TERM_NEG;
        end else if (i_q == k_q) begin
          mode1_d = TERM_DIFF;
        end else begin
          mode1_d = TERM_NEG_SUM;
        end
        i_d = i_q + 1'b1;
        j_d = j_next;
      end
      ACT_ACC_FETCH: begin
        acc_re = 1'b1;
      end
      ACT_ACC_WB: begin
        acc_we    = 1'b1;
        acc_wdata = (clear_q ? 64'd0 : acc_rdata_q) + sum_q;
        k_d       = k_q + 1'b1;
        i_d       = '0;
        j_d       = k_q + 1'b1;
        sum_clr   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // term operand: b_j, b_0 - b_{n-1}, or b_j + b_{j-1} taken negative later
  assign b0x = 33'(b0_rd_q);
  assign b1x = 33'(b1_rd_q);
  always_comb begin
    case (mode1_q)
      TERM_PLAIN, TERM_NEG: d1 = b0x;
      TERM_DIFF:            d1 = b0x - b1x;
      default:              d1 = b0x + b1x;
    endcase
  end

  assign prod = a2_q * d2_q;

  always_comb begin
    sum_d = sum_q;
    if (sum_clr) begin
      sum_d = '0;
    end else if (v3_q) begin
      sum_d = neg3_q ? sum_q - p_q : sum_q + p_q;
    end
  end

  assign m_valid_d = out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : m_valid_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= S_CLR;
      k_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      sum_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      pc_q      <= pc_d;
      k_q       <= k_d;
      i_q       <= i_d;
      j_q       <= j_d;
      v1_q      <= v1_d;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      sum_q     <= sum_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_in_fire) begin
      idx_q    <= s_axis_tdata_i[5:0];
      coef_a_q <= s_axis_tdata_i[37:6];
      coef_b_q <= s_axis_tdata_i[69:38];
      clear_q  <= s_axis_tdata_i[70];
    end
    mode1_q <= mode1_d;
    a2_q    <= a_rd_q;
    d2_q    <= d1;
    neg2_q  <= (mode1_q == TERM_NEG_SUM) || (mode1_q == TERM_NEG);
    p_q     <= prod[63:0];
    neg3_q  <= neg2_q;
    if (out_load) begin
      m_data_q <= idx_ok ? acc_rdata_q : 64'd0;
    end
  end

  // operand memories: one write port, a read on a and two reads on b
  always_ff @(posedge clk_i) begin
    if (op_we) begin
      mem_a_q[IW'(idx_q)] <= coef_a_q;
      mem_b_q[IW'(idx_q)] <= coef_b_q;
    end
    if (op_re) begin
      a_rd_q  <= mem_a_q[i_q];
      b0_rd_q <= mem_b_q[j_q];
      b1_rd_q <= mem_b_q[j_next];
    end
  end

  // accumulator memory: one write port, one read port
  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      mem_acc_q[acc_waddr] <= acc_wdata;
    end
    if (acc_re) begin
      acc_rdata_q <= mem_acc_q[acc_raddr];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `RPMT_ASSERT_IMP(a_wb_drained, clk_i, rst_ni, pc_q == S_MAC_WB, !v1_q && !v2_q && !v3_q, "product pipeline not empty at write-back")
  `RPMT_ASSERT_IMP(a_diag_index, clk_i, rst_ni, (pc_q == S_MAC_ISSUE) && (i_q == k_q), j_q == '0, "b index not zero on the diagonal term")
  `RPMT_ASSERT_NXT(a_read_dispatch, clk_i, rst_ni, s_in_fire && (s_axis_tuser_i == KIND_READ), pc_q == S_RD0, "read item not dispatched")
  `RPMT_ASSERT_IMP(a_acc_port, clk_i, rst_ni, acc_we, !acc_re, "accumulator read and write in one cycle")

endmodule

/* tb/tb_ring_poly_mac_trinomial.sv */
// self-checking bench for ring_poly_mac_trinomial: directed table, then random load/multiply/read
// traffic with its own ring multiply-accumulate predictor; depends on rpmt_pkg and the block
`timescale 1ns / 1ps

module tb_ring_poly_mac_trinomial;
  import rpmt_pkg::*;

  localparam int N = 64;                       // polynomial degree of the block
  localparam logic [1:0] KIND_UNUSED = 2'd3;   // kind the block drops without a result
  localparam int N_RANDOM = 1000;              // random items that the block acts on
  localparam int MAX_RANDOM_MAC = 60;          // cap on random multiplies, which are long
  localparam int QUIET_TAIL = 150;             // last items run with no idling
  localparam int HOLD_CYCLES = 400;            // long output hold-off
  localparam int DRAIN_CYCLES = 100;
  localparam longint LIMIT_NS = 64'd20_000_000;
  localparam int C_MIN = 32'sh8000_0000;
  localparam int C_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  idx;
    int          a;
    int          b;
    bit          clr;
    bit          typed;      // expected value written into the row
    logic [63:0] value;
  } row_t;

  localparam int N_DIR = 25;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [71:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [63:0] m_axis_tdata_o;

  // predictor state
  int          mdl_a [N];
  int          mdl_b [N];
  logic [63:0] mdl_acc [N];
  bit          loaded [N];

  logic [63:0] exp_coef_q [$];
  logic [63:0] want;
  int          err_cnt = 0;
  int          idle_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;
  row_t        dir_rows [N_DIR];

  ring_poly_mac_trinomial #(
    .DEGREE(N)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),     // coef_index[5:0], coef_a[37:6], coef_b[69:38], clear_first[70]
    .s_axis_tuser_i (s_user),     // kind[1:0]
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o)  // read_value[63:0]
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // product of the two operands in Z[x]/(x^N+x+1) added into the accumulator;
  // a term landing at N+k folds back as -x^k - x^(k+1)
  task automatic ring_accumulate(input bit clr);
    longint p;
    int     s;
    if (clr) begin
      for (int k = 0; k < N; k++) mdl_acc[k] = '0;
    end
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        p = longint'(mdl_a[i]) * longint'(mdl_b[j]);
        s = i + j;
        if (s < N) begin
          mdl_acc[s] = mdl_acc[s] + p;
        end else begin
          mdl_acc[s - N]     = mdl_acc[s - N] - p;
          mdl_acc[s - N + 1] = mdl_acc[s - N + 1] - p;
        end
      end
    end
  endtask

  // one item transfer on the input side, then the predictor sees it
  task automatic issue_item(input logic [1:0] kind, input logic [5:0] idx, input int a,
                            input int b, input bit clr, input bit typed,
                            input logic [63:0] typed_val);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {1'b0, clr, b, a, idx};
    s_user  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    case (kind)
      KIND_LOAD: begin
        mdl_a[idx]  = a;
        mdl_b[idx]  = b;
        loaded[idx] = 1'b1;
      end
      KIND_MAC: ring_accumulate(clr);
      KIND_READ: exp_coef_q.push_back(typed ? typed_val : mdl_acc[idx]);
      default: ;  // unused kind, dropped
    endcase
  endtask

  function automatic int pick_coef();
    case ($urandom_range(0, 7))
      0: return C_MIN;
      1: return C_MAX;
      2: return 0;
      3: return -1;
      default: return int'($urandom);
    endcase
  endfunction

  // output side: random ready bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        m_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 4) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // result checking against the oldest expected coefficient
  always @(posedge clk_i) begin
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      if (exp_coef_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata_o);
      end else begin
        want = exp_coef_q.pop_front();
        if (m_axis_tdata_o !== want) begin
          err_cnt++;
          $display("%0t: read_value mismatch, expected %h, actual %h", $time, want,
                   m_axis_tdata_o);
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int          n_done;
    int          mac_cnt;
    int          pick;
    bit          hold_done;

    // reset reads come back zero, the unused kind changes nothing, extreme
    // operands at both ends of the polynomial exercise the wrap-around fold
    dir_rows = '{
      '{KIND_READ,   6'd0,  0,     0,     1'b0, 1'b1, 64'd0},
      '{KIND_READ,   6'd63, 0,     0,     1'b0, 1'b1, 64'd0},
      '{KIND_UNUSED, 6'd63, -1,    -1,    1'b1, 1'b0, 64'd0},
      '{KIND_READ,   6'd32, 0,     0,     1'b0, 1'b1, 64'd0},
      '{KIND_LOAD,   6'd0,  1,     1,     1'b0, 1'b0, 64'd0},
      '{KIND_LOAD,   6'd63, C_MIN, C_MIN, 1'b0, 1'b0, 64'd0},
      '{KIND_LOAD,   6'd1,  C_MAX, C_MAX, 1'b0, 1'b0, 64'd0},
      '{KIND_LOAD,   6'd62, -1,    C_MIN, 1'b0, 1'b0, 64'd0},
      '{KIND_MAC,    6'd0,  0,     0,     1'b1, 1'b0, 64'd0},
      '{KIND_READ,   6'd0,  0,     0,     1'b0, 1'b0, 64'd0},
      '{KIND_READ,   6'd1,  0,     0,     1'b0, 1'b0, 64'd0},
      '{KIND_READ,   6'd62, 0,     0,     1'b0, 1'b0, 64'd0},
      '{KIND_READ,   6'd63, 0,     0,     1'b0, 1'b0, 64'd0},
      '{KIND_MAC,    6'd5,  -1,    -1,    1'b0, 1'b0, 64'd0},
      '{KIND_READ,   6'd63, 0,     0,     1'b0, 1'b0, 64'd0},
      '{KIND_READ,   6'd2,  0,     0,     1'b0, 1'b0, 64'd0},
      '{KIND_LOAD,   6'd0,  C_MIN, C_MAX, 1'b0, 1'b0, 64'd0},
      '{KIND_MAC,    6'd0,  0,     0,     1'b1, 1'b0, 64'd0},
      '{KIND_READ,   6'd0,  0,     0,     1'b0, 1'b0, 64'd0},
      '{KIND_READ,   6'd63, 0,     0,     1'b0, 1'b0, 64'd0},
      '{KIND_MAC,    6'd0,  0,     0,     1'b0, 1'b0, 64'd0},
      '{KIND_READ,   6'd62, 0,     0,     1'b0, 1'b0, 64'd0},
      '{KIND_READ,   6'd0,  0,     0,     1'b0, 1'b0, 64'd0},
      '{KIND_READ,   6'd1,  0,     0,     1'b0, 1'b0, 64'd0},
      '{KIND_READ,   6'd63, 0,     0,     1'b0, 1'b0, 64'd0}
    };
    for (int k = 0; k < N; k++) begin
      mdl_a[k]   = 0;
      mdl_b[k]   = 0;
      mdl_acc[k] = '0;
      loaded[k]  = 1'b0;
    end

    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed part; a multiply never touches an operand entry not yet written,
    // so the gaps are loaded with zeros just before the first one
    idle_pct = 20;
    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].kind == KIND_MAC) begin
        for (int k = 0; k < N; k++) begin
          if (!loaded[k]) issue_item(KIND_LOAD, 6'(k), 0, 0, 1'b0, 1'b0, '0);
        end
      end
      issue_item(dir_rows[r].kind, dir_rows[r].idx, dir_rows[r].a, dir_rows[r].b,
                 dir_rows[r].clr, dir_rows[r].typed, dir_rows[r].value);
    end

    // random part: loads and reads with multiplies spread among them
    n_done    = 0;
    mac_cnt   = 0;
    hold_done = 1'b0;
    while (n_done < N_RANDOM) begin
      if (n_done >= N_RANDOM - QUIET_TAIL) begin
        idle_pct = 0;
      end else if (n_done % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if (!hold_done && n_done >= 300) begin
        // reads pile up behind a held output until the input stalls
        hold_done = 1'b1;
        hold_req  = 1'b1;
        repeat (8) issue_item(KIND_READ, 6'($urandom_range(0, N - 1)), int'($urandom),
                              int'($urandom), 1'($urandom), 1'b0, '0);
        n_done += 8;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          issue_item(KIND_UNUSED, 6'($urandom), int'($urandom), int'($urandom),
                     1'($urandom), 1'b0, '0);
        end else if (pick < 52) begin
          issue_item(KIND_LOAD, 6'($urandom_range(0, N - 1)), pick_coef(), pick_coef(),
                     1'($urandom), 1'b0, '0);
          n_done++;
        end else if (pick < 92 || mac_cnt >= MAX_RANDOM_MAC) begin
          issue_item(KIND_READ, 6'($urandom_range(0, N - 1)), int'($urandom),
                     int'($urandom), 1'($urandom), 1'b0, '0);
          n_done++;
        end else begin
          issue_item(KIND_MAC, 6'($urandom), int'($urandom), int'($urandom),
                     1'($urandom), 1'b0, '0);
          mac_cnt++;
          n_done++;
        end
      end
    end
    s_valid <= 1'b0;

    while (exp_coef_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
